FILE: hw/rtl/pir_motion_trigger_qualifier_defines.svh
// assertion macros for the motion trigger qualifier
// used by the top level; expects clk and arst_n in scope
`ifndef PIR_MOTION_TRIGGER_QUALIFIER_DEFINES_SVH
`define PIR_MOTION_TRIGGER_QUALIFIER_DEFINES_SVH
`ifndef SYNTHESIS
`define PMTQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PMTQ_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);
`else
`define PMTQ_ASSERT(label, prop, msg)
`define PMTQ_ASSERT_IMPL(label, pre, post, msg)
`endif
`endif

FILE: hw/rtl/pmtq_pkg.sv
// types and constants of the motion trigger qualifier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pmtq_pkg;
	localparam int DIV_W = 50;
	localparam int QUO_W = 17;
	// hours since zero: (now >> 7) * HOUR_RECIP >> 40, exact for any 32-bit now
	localparam logic [25:0] HOUR_RECIP = 26'd39093747;
	// hours / 24: h * DAY_RECIP >> 16, exact below 2048 hours
	localparam logic [11:0] DAY_RECIP = 12'd2731;
	localparam logic [10:0] HOURS_PER_DAY = 11'd24;
	localparam logic [16:0] Q16_ONE = 17'd65536;
	localparam logic [31:0] CNT_MAX = 32'hFFFFFFFF;

	typedef enum logic [2:0] {
		REG_ENABLE = 3'd0,
		REG_DEBOUNCE = 3'd1,
		REG_SENS = 3'd2,
		REG_WIND = 3'd3,
		REG_TEMP = 3'd4,
		REG_HUMID = 3'd5,
		REG_LIGHT = 3'd6,
		REG_DAYTIME = 3'd7
	} reg_idx_t;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_HDAY = 10'b0000000010,
		ST_LDHR = 10'b0000000100,
		ST_HHR = 10'b0000001000,
		ST_SCORE = 10'b0000010000,
		ST_LDCF = 10'b0000100000,
		ST_CONF = 10'b0001000000,
		ST_MEAN = 10'b0010000000,
		ST_AVG = 10'b0100000000,
		ST_DONE = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] dvs;
	} div_cmd_t;
endpackage
`default_nettype wire

FILE: hw/rtl/pmtq_divider.sv
// restoring divide step unit shared by the confidence and running-mean divisions of the qualifier
// depends on pmtq_pkg
`timescale 1ns / 1ps
`default_nettype none
module pmtq_divider import pmtq_pkg::*; (
	input wire logic clk,
	input wire div_cmd_t cmd,
	output logic [QUO_W-1:0] quo
);
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvs_q;
	logic [QUO_W-1:0] quo_q;
	logic fits;

	assign fits = rem_q >= dvs_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= cmd.rem;
			dvs_q <= cmd.dvs;
			quo_q <= '0;
		end else if (cmd.step) begin
			if (fits) begin
				rem_q <= rem_q - dvs_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
			dvs_q <= dvs_q >> 1;
		end
	end

	assign quo = quo_q;
endmodule
`default_nettype wire

FILE: hw/rtl/pir_motion_trigger_qualifier.sv
// motion trigger qualifier top level
// samples come in on s_*, one result word per sample leaves on m_*.
// registers are written over the apb port; the user must do so only while the
// block is idle, the block itself does not enforce it. a sample that is not a
// qualifying rising edge (or arrives while disabled) goes straight from accept
// to the last step. for a scored edge the hour comes from two reciprocal
// multiplies and a subtraction (ST_HDAY, ST_LDHR, ST_HHR), then one shared
// restoring divider runs the confidence divide (17 steps) and, on a detection
// with the counter not saturated, the running-mean divide (17 steps) one bit
// per cycle. s_tready is high only while no sample is in work, so a new sample
// is not accepted before the previous one has left the last step.
// the result sits in an output register; while the receiver stalls the
// next sample may still be accepted and worked on, and it waits in the
// last step until the register frees up.
// reset clears the counters, the trigger and detection timestamps and the mean
// and loads the register defaults (enabled, 1000 ms debounce, unit sensitivity).
`timescale 1ns / 1ps
`default_nettype none
`include "pir_motion_trigger_qualifier_defines.svh"
module pir_motion_trigger_qualifier import pmtq_pkg::*; #(
	parameter int WIND_LIMIT_TENTHS = 200
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// [0] sensor_level, [32:1] now_ms, [39:33] zero
	input wire logic [39:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// [0] detected, [1] rejected, [18:2] confidence, [50:19] detection_count,
	// [82:51] rejection_count, [99:83] mean_confidence,
	// [131:100] last_detect_ms, [135:132] zero
	output logic [135:0] m_tdata,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam logic [10:0] WIND_LIMIT = 11'(WIND_LIMIT_TENTHS);

	logic enable_q;
	logic [15:0] debounce_q;
	logic [16:0] sens_q;
	logic [10:0] wind_q;
	logic signed [11:0] temp_q;
	logic [9:0] humid_q;
	logic [9:0] light_q;
	logic daytime_q;

	state_t state_q;
	logic [4:0] cnt_q;
	logic prev_q;
	logic [31:0] last_trig_q;
	logic [31:0] acc_total_q;
	logic [31:0] rej_total_q;
	logic [16:0] avg_q;
	logic [31:0] last_det_q;
	logic [31:0] now_q;
	logic scored_q;
	logic det_q;
	logic upd_avg_q;
	logic [16:0] conf_q;
	logic [33:0] prod_q;
	logic [18:0] den_q;
	logic [10:0] hrs_q;
	logic [6:0] q24_q;
	logic [4:0] hour_q;

	div_cmd_t cmd;
	logic [QUO_W-1:0] div_quo;

	logic accept;
	logic out_free;
	logic wr;
	logic edge_seen;
	logic [31:0] elapsed;
	logic [50:0] hprod;
	logic [22:0] dprod;
	logic [10:0] hr_left;
	logic [16:0] num;
	logic [18:0] den;
	logic [16:0] sens_c;
	logic [37:0] prod10;
	logic [37:0] thresh;
	logic [16:0] conf_c;
	logic [31:0] n_c;
	logic [48:0] mprod;
	logic [31:0] acc_nx;
	logic [31:0] rej_nx;
	logic [16:0] avg_nx;
	logic [31:0] last_det_nx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign s_tready = state_q == ST_IDLE;
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign edge_seen = s_tdata[0] && !prev_q;
	assign elapsed = s_tdata[32:1] - last_trig_q;
	assign hprod = now_q[31:7] * HOUR_RECIP;
	assign dprod = hrs_q * DAY_RECIP;
	assign hr_left = hrs_q - {4'd0, q24_q} * HOURS_PER_DAY;
	assign sens_c = sens_q > Q16_ONE ? Q16_ONE : sens_q;
	assign prod10 = {1'b0, prod_q, 3'b000} + {3'b000, prod_q, 1'b0};
	assign thresh = {1'b0, 21'(den_q * 21'd3), 16'd0};
	assign conf_c = div_quo > Q16_ONE ? Q16_ONE : div_quo;
	assign n_c = acc_total_q + 32'd1;
	assign mprod = avg_q * acc_total_q;

	pmtq_divider u_div (
		.clk(clk),
		.cmd(cmd),
		.quo(div_quo)
	);

	// confidence factors as exact ratios
	always_comb begin
		num = 17'd4;
		den = 19'd5;
		if ((hour_q >= 5'd5 && hour_q <= 5'd8) || (hour_q >= 5'd17 && hour_q <= 5'd20)) begin
			num = 17'(num * 17'd11);
			den = 19'(den * 19'd10);
		end
		if (humid_q >= 10'd400 && humid_q <= 10'd700) begin
			num = 17'(num * 17'd21);
			den = 19'(den * 19'd20);
		end
		if (wind_q > WIND_LIMIT) begin
			num = 17'(num * 17'd3);
			den = 19'(den * 19'd10);
		end
		if (temp_q < 12'sd50 || temp_q > 12'sd350) begin
			num = 17'(num * 17'd7);
			den = 19'(den * 19'd10);
		end
		if (!daytime_q && light_q < 10'd100) begin
			num = 17'(num * 17'd6);
			den = 19'(den * 19'd5);
		end else if (light_q > 10'd900) begin
			num = 17'(num * 17'd4);
			den = 19'(den * 19'd5);
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_LDCF: begin
				cmd.load = 1'b1;
				cmd.rem = DIV_W'(prod_q) + DIV_W'(den_q[18:1]);
				cmd.dvs = DIV_W'(den_q) << 16;
			end
			ST_MEAN: begin
				cmd.load = 1'b1;
				cmd.rem = DIV_W'(mprod) + DIV_W'(conf_c) + DIV_W'(n_c[31:1]);
				cmd.dvs = DIV_W'(n_c) << 16;
			end
			ST_CONF, ST_AVG: cmd.step = 1'b1;
			ST_IDLE, ST_HDAY, ST_LDHR, ST_HHR, ST_SCORE, ST_DONE: ;
			default: ;
		endcase
	end

	// state after this sample's commit
	always_comb begin
		acc_nx = acc_total_q;
		rej_nx = rej_total_q;
		avg_nx = avg_q;
		last_det_nx = last_det_q;
		if (det_q) begin
			last_det_nx = now_q;
			if (upd_avg_q) begin
				acc_nx = n_c;
				avg_nx = div_quo;
			end
		end else if (scored_q && rej_total_q != CNT_MAX) begin
			rej_nx = rej_total_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			debounce_q <= 16'd1000;
			sens_q <= Q16_ONE;
			wind_q <= '0;
			temp_q <= 12'sd200;
			humid_q <= 10'd500;
			light_q <= 10'd500;
			daytime_q <= 1'b1;
		end else if (wr) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_ENABLE: enable_q <= pwdata[0];
				REG_DEBOUNCE: debounce_q <= pwdata[15:0];
				REG_SENS: sens_q <= pwdata[16:0];
				REG_WIND: wind_q <= pwdata[10:0];
				REG_TEMP: temp_q <= pwdata[11:0];
				REG_HUMID: humid_q <= pwdata[9:0];
				REG_LIGHT: light_q <= pwdata[9:0];
				REG_DAYTIME: daytime_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_ENABLE: prdata = {31'd0, enable_q};
			REG_DEBOUNCE: prdata = {16'd0, debounce_q};
			REG_SENS: prdata = {15'd0, sens_q};
			REG_WIND: prdata = {21'd0, wind_q};
			REG_TEMP: prdata = {20'd0, temp_q};
			REG_HUMID: prdata = {22'd0, humid_q};
			REG_LIGHT: prdata = {22'd0, light_q};
			REG_DAYTIME: prdata = {31'd0, daytime_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			prev_q <= 1'b0;
			last_trig_q <= '0;
			acc_total_q <= '0;
			rej_total_q <= '0;
			avg_q <= '0;
			last_det_q <= '0;
			scored_q <= 1'b0;
			det_q <= 1'b0;
			upd_avg_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && !(state_q == ST_DONE && out_free)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						now_q <= s_tdata[32:1];
						scored_q <= 1'b0;
						det_q <= 1'b0;
						upd_avg_q <= 1'b0;
						conf_q <= '0;
						state_q <= ST_DONE;
						if (enable_q) begin
							prev_q <= s_tdata[0];
							if (edge_seen && elapsed >= 32'(debounce_q)) begin
								state_q <= ST_HDAY;
							end
						end
					end
				end
				ST_HDAY: begin
					hrs_q <= hprod[50:40];
					state_q <= ST_LDHR;
				end
				ST_LDHR: begin
					q24_q <= dprod[22:16];
					state_q <= ST_HHR;
				end
				ST_HHR: begin
					hour_q <= hr_left[4:0];
					state_q <= ST_SCORE;
				end
				ST_SCORE: begin
					prod_q <= num * sens_c;
					den_q <= den;
					state_q <= ST_LDCF;
				end
				ST_LDCF: begin
					scored_q <= 1'b1;
					det_q <= prod10 > thresh;
					cnt_q <= 5'd16;
					state_q <= ST_CONF;
				end
				ST_CONF: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					conf_q <= conf_c;
					cnt_q <= 5'd16;
					// saturated counter freezes the mean
					if (det_q && acc_total_q != CNT_MAX) begin
						upd_avg_q <= 1'b1;
						state_q <= ST_AVG;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_AVG: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						acc_total_q <= acc_nx;
						rej_total_q <= rej_nx;
						avg_q <= avg_nx;
						last_det_q <= last_det_nx;
						if (det_q) last_trig_q <= now_q;
						m_tvalid <= 1'b1;
						m_tdata <= {4'd0, last_det_nx, avg_nx, rej_nx, acc_nx, conf_q,
							scored_q && !det_q, det_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PMTQ_ASSERT(a_flags_excl, m_tvalid |-> !(m_tdata[0] && m_tdata[1]), "detected and rejected both set")
	`PMTQ_ASSERT(a_conf_range, m_tvalid |-> (m_tdata[18:2] <= Q16_ONE), "confidence above one")
	`PMTQ_ASSERT_IMPL(a_busy, accept, !s_tready, "ready right after accept")
	`PMTQ_ASSERT(a_unscored_zero, (m_tvalid && !m_tdata[0] && !m_tdata[1]) |-> (m_tdata[18:2] == '0), "confidence on unscored word")
endmodule
`default_nettype wire

FILE: sim/tb_pir_motion_trigger_qualifier.sv
// testbench for the motion trigger qualifier: drives samples and register writes,
// predicts every result word and checks it field by field; needs pmtq_pkg and the rtl
`timescale 1ns / 1ps

class trigger_scoreboard;
	// register copy
	bit en;
	bit [15:0] debounce;
	bit [16:0] sens;
	bit [10:0] wind;
	bit signed [11:0] temp;
	bit [9:0] humid;
	bit [9:0] light;
	bit daytime;
	// block state copy
	bit prev_level;
	bit [31:0] last_trig;
	bit [31:0] det_total;
	bit [31:0] rej_total;
	bit [16:0] mean_conf;
	bit [31:0] last_det;
	bit [135:0] pending_words[$];
	int errors;

	function void reset_state();
		en = 1; debounce = 1000; sens = 17'd65536; wind = 0; temp = 200;
		humid = 500; light = 500; daytime = 1;
		prev_level = 0; last_trig = 0; det_total = 0; rej_total = 0;
		mean_conf = 0; last_det = 0; errors = 0;
		pending_words.delete();
	endfunction

	function void write_reg(pmtq_pkg::reg_idx_t idx, bit [31:0] v);
		case (idx)
			pmtq_pkg::REG_ENABLE: en = v[0];
			pmtq_pkg::REG_DEBOUNCE: debounce = v[15:0];
			pmtq_pkg::REG_SENS: sens = v[16:0];
			pmtq_pkg::REG_WIND: wind = v[10:0];
			pmtq_pkg::REG_TEMP: temp = v[11:0];
			pmtq_pkg::REG_HUMID: humid = v[9:0];
			pmtq_pkg::REG_LIGHT: light = v[9:0];
			default: daytime = v[0];
		endcase
	endfunction

	function void note_sample(bit level, bit [31:0] now);
		bit det, rej;
		bit [16:0] conf;
		bit [63:0] num, den, prod, q, n, acc, s;
		int unsigned hour;
		det = 0; rej = 0; conf = 0;
		if (en) begin
			if (level && !prev_level && (now - last_trig) >= {16'd0, debounce}) begin
				num = 4; den = 5;
				hour = (now / 32'd3600000) % 24;
				s = (sens > 17'd65536) ? 64'd65536 : 64'(sens);
				if ((hour >= 5 && hour <= 8) || (hour >= 17 && hour <= 20)) begin
					num *= 11; den *= 10;
				end
				if (humid >= 400 && humid <= 700) begin
					num *= 21; den *= 20;
				end
				if (wind > 200) begin
					num *= 3; den *= 10;
				end
				if (temp < 50 || temp > 350) begin
					num *= 7; den *= 10;
				end
				if (!daytime && light < 100) begin
					num *= 6; den *= 5;
				end else if (light > 900) begin
					num *= 4; den *= 5;
				end
				prod = num * s;
				q = (prod + den / 2) / den;
				conf = (q > 65536) ? 17'd65536 : q[16:0];
				if (prod * 10 > den * 3 * 65536) begin
					det = 1;
					if (det_total != 32'hFFFFFFFF) begin
						n = 64'(det_total) + 1;
						acc = 64'(mean_conf) * (n - 1) + conf;
						det_total = n[31:0];
						mean_conf = 17'((acc + n / 2) / n);
					end
					last_det = now;
					last_trig = now;
				end else begin
					rej = 1;
					if (rej_total != 32'hFFFFFFFF) rej_total++;
				end
			end
			prev_level = level;
		end
		pending_words.push_back({4'd0, last_det, mean_conf, rej_total, det_total, conf, rej, det});
	endfunction

	function void check_word(bit [135:0] got);
		bit [135:0] exp;
		if (pending_words.size() == 0) begin
			$display("%0t: unexpected result word %h", $time, got);
			errors++;
			return;
		end
		exp = pending_words.pop_front();
		if (got[0] !== exp[0] || got[1] !== exp[1] || got[18:2] !== exp[18:2] ||
				got[50:19] !== exp[50:19] || got[82:51] !== exp[82:51] ||
				got[99:83] !== exp[99:83] || got[131:100] !== exp[131:100] ||
				got[135:132] !== exp[135:132]) begin
			$display("%0t: result mismatch expected %h actual %h", $time, exp, got);
			errors++;
		end
	endfunction
endclass

module tb_pir_motion_trigger_qualifier;
	import pmtq_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [135:0] m_tdata;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	trigger_scoreboard sb;
	bit quiet_tail;
	bit [31:0] clock_ms;

	always #5 clk = ~clk;

	pir_motion_trigger_qualifier u_top (.*);

	// receiver: random stall bursts
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_word(m_tdata);
			if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				m_tready <= 0;
				gap = $urandom_range(1, 19);
				repeat (gap) begin
					@(posedge clk);
					if (m_tvalid && m_tready) sb.check_word(m_tdata);
				end
			end
			m_tready <= 1;
		end
	end

	task automatic wait_drained();
		s_tvalid <= 0;
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, bit [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx) << 2; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		sb.write_reg(idx, v);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	// tvalid stays high after an accept; the block is busy in the next cycle
	task automatic send_sample(bit level, bit [31:0] now);
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {7'd0, now, level};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(level, now);
	endtask

	// rising edge with a time step that usually clears debounce
	task automatic send_pulse(int unsigned step);
		clock_ms += step;
		send_sample(0, clock_ms);
		clock_ms += $urandom_range(0, 50);
		send_sample(1, clock_ms);
	endtask

	task automatic random_env();
		write_reg(REG_ENABLE, ($urandom_range(0, 9) != 0));
		write_reg(REG_DEBOUNCE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000));
		write_reg(REG_SENS, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536));
		write_reg(REG_WIND, $urandom_range(0, 1) ? $urandom : $urandom_range(150, 250));
		write_reg(REG_TEMP, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 400));
		write_reg(REG_HUMID, $urandom);
		write_reg(REG_LIGHT, $urandom);
		write_reg(REG_DAYTIME, $urandom);
	endtask

	initial begin
		int n;
		sb = new();
		sb.reset_state();
		quiet_tail = 0;
		clock_ms = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, edges, debounce boundary, wrap, extremes
		send_sample(1, 1000);
		send_sample(1, 5000);
		send_sample(0, 5100);
		send_sample(1, 5999);
		send_sample(0, 6000);
		send_sample(1, 6999);
		send_sample(0, 7000);
		send_sample(1, 32'hFFFFFFFF);
		send_sample(0, 0);
		send_sample(1, 32'd5 * 32'd3600000);
		wait_drained();
		write_reg(REG_DEBOUNCE, 0);
		write_reg(REG_SENS, 32'h1FFFF);
		write_reg(REG_WIND, 2047);
		write_reg(REG_TEMP, 32'hFFFFF800);
		write_reg(REG_HUMID, 1023);
		write_reg(REG_LIGHT, 0);
		write_reg(REG_DAYTIME, 0);
		send_sample(0, 1);
		send_sample(1, 1);
		wait_drained();
		write_reg(REG_WIND, 0);
		send_sample(0, 2);
		send_sample(1, 2);
		wait_drained();
		write_reg(REG_SENS, 0);
		write_reg(REG_LIGHT, 1023);
		write_reg(REG_DAYTIME, 1);
		write_reg(REG_DEBOUNCE, 65535);
		send_sample(0, 3);
		send_sample(1, 32'hFFFFFFFE);
		wait_drained();
		write_reg(REG_ENABLE, 0);
		send_sample(1, 100);
		send_sample(0, 200);
		wait_drained();
		write_reg(REG_ENABLE, 1);
		write_reg(REG_TEMP, 2047);
		write_reg(REG_SENS, 65536);
		send_sample(1, 300);
		wait_drained();

		// random phases with new settings
		clock_ms = $urandom;
		n = 0;
		while (n < 1700) begin
			random_env();
			repeat (40) begin
				if ($urandom_range(0, 4) == 0) begin
					clock_ms += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000);
					send_sample($urandom, $urandom_range(0, 3) == 0 ? $urandom : clock_ms);
					n++;
				end else begin
					send_pulse($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000));
					n += 2;
				end
			end
			wait_drained();
		end
		quiet_tail = 1;
		write_reg(REG_ENABLE, 1);
		write_reg(REG_DEBOUNCE, 10);
		repeat (30) send_pulse($urandom_range(0, 200));

		s_tvalid <= 0;
		n = 0;
		while (sb.pending_words.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending_words.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/pmtq_pkg.sv
hw/rtl/pmtq_divider.sv
hw/rtl/pir_motion_trigger_qualifier.sv
sim/tb_pir_motion_trigger_qualifier.sv
